### rtl/core/vnrm_pkg.sv
// ----------------------------------------------------------------------------
// vnrm_pkg: shared types and constants for the vector Euclidean norm block
// Holds the fixed accumulator and root widths, the register map, the square
// root unit state encoding and the structs that pass results between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package vnrm_pkg;

	// Running sum of squares, unsigned Q18.30, saturating at all ones.
	localparam int SUM_BITS  = 48;
	// Floor square root of the sum, unsigned Q9.15.
	localparam int NORM_BITS = SUM_BITS / 2;
	// Partial remainder of the digit-by-digit root never exceeds 2*root.
	localparam int REM_BITS  = NORM_BITS + 2;
	localparam int CNT_BITS  = $clog2(NORM_BITS);

	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	// Register map: one word per register, index taken from paddr[2].
	localparam int          APB_ADDR_BITS    = 3;
	localparam int          APB_DATA_BITS    = 32;
	localparam logic [0:0]  REG_COMPLEX_MODE = 1'b0;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_DONE
	} sqrt_state_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] sum;
		logic                sat;
	} sum_result_t;

	typedef struct packed {
		logic [NORM_BITS-1:0] norm;
		logic                 sat;
	} norm_result_t;

endpackage

`default_nettype wire

### rtl/core/vnrm_square_lane.sv
// ----------------------------------------------------------------------------
// vnrm_square_lane: one squaring lane
// Squares a signed sample and registers the result; a gated lane loads zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vnrm_square_lane #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         load,
	input  wire logic                         gate,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic         [2*SAMPLE_BITS-1:0]   sq_s1
);

	logic signed [2*SAMPLE_BITS-1:0] prod;

	// The most negative sample squares to a positive value that still fits.
	assign prod = sample * sample;

	always_ff @(posedge clk) begin
		if (load) begin
			sq_s1 <= gate ? $unsigned(prod) : '0;
		end
	end

endmodule

`default_nettype wire

### rtl/core/vnrm_accum.sv
// ----------------------------------------------------------------------------
// vnrm_accum: merging stage and saturating accumulator
// Adds the lane squares into the running sum and hands the final sum of a
// vector to the square root unit, clearing itself for the next vector.
// ----------------------------------------------------------------------------
`default_nettype none

module vnrm_accum #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_last,
	input  wire logic [2*SAMPLE_BITS-1:0]   sq_re,
	input  wire logic [2*SAMPLE_BITS-1:0]   sq_im,
	input  wire logic                       root_ready,
	output logic                            take,
	output logic                            start,
	output vnrm_pkg::sum_result_t           start_data
);

	localparam int SQ_BITS  = 2 * SAMPLE_BITS;
	localparam int PAD_BITS = vnrm_pkg::SUM_BITS + 1 - SQ_BITS;

	logic [vnrm_pkg::SUM_BITS-1:0] sum_q;
	logic                          sat_q;
	logic [vnrm_pkg::SUM_BITS:0]   total;
	logic                          over;
	logic [vnrm_pkg::SUM_BITS-1:0] new_sum;
	logic                          new_sat;

	// Reaching full scale counts as saturation, just as passing it does.
	assign total   = {1'b0, sum_q} + {{PAD_BITS{1'b0}}, sq_re} + {{PAD_BITS{1'b0}}, sq_im};
	assign over    = total >= {1'b0, vnrm_pkg::SUM_MAX};
	assign new_sum = over ? vnrm_pkg::SUM_MAX : total[vnrm_pkg::SUM_BITS-1:0];
	assign new_sat = sat_q | over;

	// A last item can only move on when the root unit can take its sum.
	assign take  = in_valid && (!in_last || root_ready);
	assign start = in_valid && in_last && root_ready;

	assign start_data.sum = new_sum;
	assign start_data.sat = new_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sat_q <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				sum_q <= '0;
				sat_q <= 1'b0;
			end else begin
				sum_q <= new_sum;
				sat_q <= new_sat;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/vnrm_sqrt.sv
// ----------------------------------------------------------------------------
// vnrm_sqrt: iterative floor square root
// Restoring digit-by-digit root, one result bit per cycle, holding its
// result until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module vnrm_sqrt (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire vnrm_pkg::sum_result_t   start_data,
	input  wire logic                    out_free,
	output logic                         ready,
	output logic                         res_valid,
	output vnrm_pkg::norm_result_t       res_data
);

	localparam logic [vnrm_pkg::CNT_BITS-1:0] LAST_STEP =
		vnrm_pkg::CNT_BITS'(vnrm_pkg::NORM_BITS - 1);

	vnrm_pkg::sqrt_state_t state_q;
	vnrm_pkg::sqrt_state_t state_d;

	logic [vnrm_pkg::SUM_BITS-1:0]  op_q;
	logic [vnrm_pkg::REM_BITS-1:0]  rem_q;
	logic [vnrm_pkg::NORM_BITS-1:0] root_q;
	logic [vnrm_pkg::CNT_BITS-1:0]  cnt_q;
	logic                           sat_q;
	logic [vnrm_pkg::REM_BITS-1:0]  rem_sh;
	logic [vnrm_pkg::REM_BITS-1:0]  trial;
	logic                           fits;
	logic                           load;
	logic                           step;

	// Bring down the next two bits of the operand and test root*4+1.
	assign rem_sh = {rem_q[vnrm_pkg::REM_BITS-3:0], op_q[vnrm_pkg::SUM_BITS-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vnrm_pkg::SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ready     = 1'b0;
		res_valid = 1'b0;
		load      = 1'b0;
		step      = 1'b0;
		case (state_q)
			vnrm_pkg::SQ_IDLE: begin
				ready = 1'b1;
				if (start) begin
					load    = 1'b1;
					state_d = vnrm_pkg::SQ_RUN;
				end
			end
			vnrm_pkg::SQ_RUN: begin
				step = 1'b1;
				if (cnt_q == LAST_STEP) begin
					state_d = vnrm_pkg::SQ_DONE;
				end
			end
			vnrm_pkg::SQ_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = vnrm_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = vnrm_pkg::SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q   <= start_data.sum;
			sat_q  <= start_data.sat;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			op_q   <= {op_q[vnrm_pkg::SUM_BITS-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[vnrm_pkg::NORM_BITS-2:0], fits};
		end
	end

	assign res_data.norm = root_q;
	assign res_data.sat  = sat_q;

endmodule

`default_nettype wire

### rtl/core/vector_euclidean_norm_top.sv
// ----------------------------------------------------------------------------
// vector_euclidean_norm_top: streaming fixed-point Euclidean norm
// Squares vector elements in two lanes, sums them with saturation and
// returns the floor square root of the sum at the end of each vector.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one vector element per item: s_tdata holds the
// real part in the low SAMPLE_BITS and the imaginary part above it, both
// signed, and s_tlast marks the final element of a vector. The APB register
// complex_mode (offset 0) selects real elements (imaginary part ignored) or
// complex elements; write it only while no vector is in flight.
// The output stream carries one item per vector: m_tdata is the norm as
// unsigned Q9.15 and m_tuser[0] flags that the running sum saturated.
// Throughput is one element per cycle while the accumulator takes items.
// The square root is a shared iterative unit producing one root bit per
// cycle, so a vector's last element waits in the squaring stage while the
// previous norm is still being computed; short vectors are thus paced by
// the root unit, which hands each norm on once the output register is free.
// A stalled receiver holds the result in the output register, then in the
// root unit, and finally backs up the input.
// Reset clears the sum, the saturation flag, complex_mode and all valids.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_euclidean_norm_top #(
	parameter  int SAMPLE_BITS   = 16,
	localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// APB configuration port
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [vnrm_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  wire logic [vnrm_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic      [vnrm_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                        pready,
	// Element stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [IN_DATA_BITS-1:0]                s_tdata,  // x_re, x_im
	input  wire logic                                   s_tlast,  // last_element
	// Norm stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic      [vnrm_pkg::NORM_BITS-1:0]         m_tdata,  // norm
	output logic      [0:0]                             m_tuser   // saturated
);

	localparam int SQ_BITS = 2 * SAMPLE_BITS;

	logic                          complex_mode_q;
	logic                          cfg_write;

	logic                          in_accept;
	logic                          valid_s1;
	logic                          last_s1;
	logic [SQ_BITS-1:0]            sq_re_s1;
	logic [SQ_BITS-1:0]            sq_im_s1;

	logic                          take;
	logic                          start;
	vnrm_pkg::sum_result_t         start_data;
	logic                          root_ready;
	logic                          res_valid;
	vnrm_pkg::norm_result_t        res_data;
	logic                          out_free;

	logic                          m_tvalid_q;
	vnrm_pkg::norm_result_t        out_q;

	// Configuration: writes land in the access phase; pready is always high.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complex_mode_q <= 1'b0;
		end else if (cfg_write && (paddr[2] == vnrm_pkg::REG_COMPLEX_MODE)) begin
			complex_mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == vnrm_pkg::REG_COMPLEX_MODE) ?
		{{(vnrm_pkg::APB_DATA_BITS-1){1'b0}}, complex_mode_q} : '0;

	// The squaring stage frees up whenever the accumulator takes its item.
	assign s_tready  = !valid_s1 || take;
	assign in_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
			last_s1  <= s_tlast;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Real part lane always squares; the imaginary lane loads zero in real mode.
	vnrm_square_lane #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_re (
		.clk    (clk),
		.load   (in_accept),
		.gate   (1'b1),
		.sample (s_tdata[SAMPLE_BITS-1:0]),
		.sq_s1  (sq_re_s1)
	);

	vnrm_square_lane #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_im (
		.clk    (clk),
		.load   (in_accept),
		.gate   (complex_mode_q),
		.sample (s_tdata[SQ_BITS-1:SAMPLE_BITS]),
		.sq_s1  (sq_im_s1)
	);

	vnrm_accum #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1),
		.in_last    (last_s1),
		.sq_re      (sq_re_s1),
		.sq_im      (sq_im_s1),
		.root_ready (root_ready),
		.take       (take),
		.start      (start),
		.start_data (start_data)
	);

	vnrm_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_data (start_data),
		.out_free   (out_free),
		.ready      (root_ready),
		.res_valid  (res_valid),
		.res_data   (res_data)
	);

	// Output register: refills in the same cycle that the receiver drains it.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res_data;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = out_q.norm;
	assign m_tuser[0] = out_q.sat;

endmodule

`default_nettype wire
